// File: rtl/vlbd_pkg.sv
// ----------------------------------------------------------------------------
// vlbd_pkg
// Shared types, codes and helpers of the variable-length bytecode decoder.
// ----------------------------------------------------------------------------
package vlbd_pkg;

  // Parse phases
  typedef enum logic [2:0] {
    PH_OPCODE = 3'd0,
    PH_SHORTC = 3'd1,
    PH_DISP   = 3'd2,
    PH_LID    = 3'd3,
    PH_LCOUNT = 3'd4,
    PH_FLAGS  = 3'd5,
    PH_INDEX  = 3'd6,
    PH_OCONST = 3'd7
  } phase_e;

  // Result classes
  localparam logic [3:0] CLS_ERROR   = 4'd0;
  localparam logic [3:0] CLS_NOP     = 4'd1;
  localparam logic [3:0] CLS_DUMP    = 4'd2;
  localparam logic [3:0] CLS_SYSCALL = 4'd3;
  localparam logic [3:0] CLS_LIBCALL = 4'd4;
  localparam logic [3:0] CLS_MODE    = 4'd5;
  localparam logic [3:0] CLS_MOVSHORT = 4'd6;
  localparam logic [3:0] CLS_JUMP    = 4'd7;
  localparam logic [3:0] CLS_CALL    = 4'd8;
  localparam logic [3:0] CLS_LONG    = 4'd9;
  localparam logic [3:0] CLS_INVALID = 4'd10;
  localparam logic [3:0] CLS_OPERAND = 4'd11;

  // Opcodes with a zero top pair
  localparam logic [7:0] OPC_ERROR   = 8'h00;
  localparam logic [7:0] OPC_LONG    = 8'h01;
  localparam logic [7:0] OPC_NOP     = 8'h02;
  localparam logic [7:0] OPC_DUMP    = 8'h03;
  localparam logic [7:0] OPC_SYSCALL = 8'h04;
  localparam logic [7:0] OPC_LIBCALL = 8'h05;
  localparam logic [7:0] OPC_MODE    = 8'h06;

  // Top pair codes
  localparam logic [1:0] TOP_SHORT = 2'b00;
  localparam logic [1:0] TOP_JUMP  = 2'b11;

  // Operand flag bits
  localparam int unsigned FB_MEM = 0;
  localparam int unsigned FB_RX  = 1;
  localparam int unsigned FB_RY  = 2;

  // Constant size codes of an operand
  localparam logic [1:0] CSZ_NONE  = 2'd0;
  localparam logic [1:0] CSZ_ONE   = 2'd1;
  localparam logic [1:0] CSZ_FOUR  = 2'd2;
  localparam logic [1:0] CSZ_EIGHT = 2'd3;

  typedef struct packed {
    logic [3:0]  op_class;
    logic [7:0]  long_id;
    logic [7:0]  arg_count;
    logic        is_memory;
    logic        has_rx;
    logic [2:0]  rx_reg;
    logic        has_ry;
    logic [2:0]  ry_reg;
    logic [1:0]  scale_log;
    logic        has_const;
    logic [63:0] const_value;
    logic        last;
  } res_t;

  function automatic res_t res_clear(input logic [3:0] cls);
    res_t r;
    r          = '0;
    r.op_class = cls;
    return r;
  endfunction

  // Bytes of constant following an operand flag byte
  function automatic logic [3:0] const_len(input logic [7:0] flags);
    logic [3:0] n;
    case (flags[4:3])
      CSZ_ONE:   n = 4'd1;
      CSZ_FOUR:  n = 4'd4;
      CSZ_EIGHT: n = 4'd8;
      default:   n = 4'd0;
    endcase
    return n;
  endfunction

  // Sign-extend a displacement whose top byte sits at lane idx
  function automatic logic [63:0] sext_disp(input logic [63:0] v, input logic [2:0] idx);
    logic [63:0] r;
    case (idx)
      3'd0:    r = {{56{v[7]}},  v[7:0]};
      3'd1:    r = {{48{v[15]}}, v[15:0]};
      3'd2:    r = {{40{v[23]}}, v[23:0]};
      3'd3:    r = {{32{v[31]}}, v[31:0]};
      3'd4:    r = {{24{v[39]}}, v[39:0]};
      3'd5:    r = {{16{v[47]}}, v[47:0]};
      3'd6:    r = {{8{v[55]}},  v[55:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  // Operand result from its flags, index byte and collected constant
  function automatic res_t emit_operand(input logic [7:0]  flags,
                                        input logic [7:0]  idx,
                                        input logic [63:0] val,
                                        input logic        is_last);
    res_t r;
    r           = res_clear(CLS_OPERAND);
    r.is_memory = flags[FB_MEM];
    r.has_rx    = flags[FB_RX];
    r.rx_reg    = flags[FB_RX] ? flags[7:5] : 3'd0;
    if (flags[FB_RY]) begin
      r.has_ry    = 1'b1;
      r.ry_reg    = idx[2:0];
      r.scale_log = idx[7:6];
    end
    if (const_len(flags) != 4'd0) begin
      r.has_const   = 1'b1;
      r.const_value = val;
    end
    r.last = is_last;
    return r;
  endfunction

endpackage

// File: rtl/vlbd_parse.sv
// ----------------------------------------------------------------------------
// vlbd_parse
// Byte-wise parse state of the instruction stream; forms one result word.
// ----------------------------------------------------------------------------
module vlbd_parse (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [7:0]    byte_i,
  output logic          res_valid_o,
  output vlbd_pkg::res_t res_o
);

  vlbd_pkg::phase_e phase_q, phase_d;
  logic [3:0]  bytes_left_q, bytes_left_d;
  logic [2:0]  byte_index_q, byte_index_d;
  logic [63:0] value_shift_q, value_shift_d;
  logic [3:0]  cur_class_q, cur_class_d;
  logic [7:0]  operands_left_q, operands_left_d;
  logic [7:0]  operand_flags_q, operand_flags_d;
  logic [7:0]  index_byte_q, index_byte_d;

  logic [1:0]  top;
  logic        regs_differ;
  logic [63:0] acc_val;
  logic [3:0]  left_dec;
  logic [7:0]  ops_dec;
  logic [3:0]  clen;

  assign top         = byte_i[7:6];
  assign regs_differ = byte_i[5:3] != byte_i[2:0];
  assign acc_val     = value_shift_q | (64'(byte_i) << {byte_index_q, 3'b000});
  assign left_dec    = bytes_left_q - 4'd1;
  assign ops_dec     = operands_left_q - 8'd1;
  assign clen        = vlbd_pkg::const_len(byte_i);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      vlbd_pkg::PH_OPCODE: begin
        if (top != vlbd_pkg::TOP_SHORT) begin
          if (!regs_differ && !byte_i[5]) phase_d = vlbd_pkg::PH_DISP;
        end else begin
          case (byte_i) inside
            vlbd_pkg::OPC_SYSCALL, vlbd_pkg::OPC_LIBCALL, vlbd_pkg::OPC_MODE:
              phase_d = vlbd_pkg::PH_SHORTC;
            vlbd_pkg::OPC_LONG: phase_d = vlbd_pkg::PH_LID;
            default:            phase_d = vlbd_pkg::PH_OPCODE;
          endcase
        end
      end
      vlbd_pkg::PH_SHORTC: phase_d = vlbd_pkg::PH_OPCODE;
      vlbd_pkg::PH_DISP: begin
        if (left_dec == 4'd0) phase_d = vlbd_pkg::PH_OPCODE;
      end
      vlbd_pkg::PH_LID:    phase_d = vlbd_pkg::PH_LCOUNT;
      vlbd_pkg::PH_LCOUNT: begin
        phase_d = (byte_i == 8'd0) ? vlbd_pkg::PH_OPCODE : vlbd_pkg::PH_FLAGS;
      end
      vlbd_pkg::PH_FLAGS: begin
        if (byte_i[vlbd_pkg::FB_RY])  phase_d = vlbd_pkg::PH_INDEX;
        else if (clen != 4'd0)        phase_d = vlbd_pkg::PH_OCONST;
        else if (ops_dec == 8'd0)     phase_d = vlbd_pkg::PH_OPCODE;
      end
      vlbd_pkg::PH_INDEX: begin
        if (bytes_left_q != 4'd0)     phase_d = vlbd_pkg::PH_OCONST;
        else if (ops_dec == 8'd0)     phase_d = vlbd_pkg::PH_OPCODE;
        else                          phase_d = vlbd_pkg::PH_FLAGS;
      end
      vlbd_pkg::PH_OCONST: begin
        if (left_dec == 4'd0) begin
          phase_d = (ops_dec == 8'd0) ? vlbd_pkg::PH_OPCODE : vlbd_pkg::PH_FLAGS;
        end
      end
      default: phase_d = vlbd_pkg::PH_OPCODE;
    endcase
  end

  // Datapath and result word
  always_comb begin
    bytes_left_d    = bytes_left_q;
    byte_index_d    = byte_index_q;
    value_shift_d   = value_shift_q;
    cur_class_d     = cur_class_q;
    operands_left_d = operands_left_q;
    operand_flags_d = operand_flags_q;
    index_byte_d    = index_byte_q;
    res_valid_o     = 1'b0;
    res_o           = vlbd_pkg::res_clear(vlbd_pkg::CLS_ERROR);
    unique case (phase_q)
      vlbd_pkg::PH_OPCODE: begin
        if (top != vlbd_pkg::TOP_SHORT) begin
          if (regs_differ) begin
            res_valid_o  = 1'b1;
            res_o        = vlbd_pkg::res_clear(vlbd_pkg::CLS_MOVSHORT);
            res_o.rx_reg = byte_i[5:3];
            res_o.ry_reg = byte_i[2:0];
            res_o.last   = 1'b1;
          end else if (byte_i[5]) begin
            res_valid_o = 1'b1;
            res_o       = vlbd_pkg::res_clear(vlbd_pkg::CLS_INVALID);
            res_o.last  = 1'b1;
          end else begin
            cur_class_d   = (top == vlbd_pkg::TOP_JUMP) ? vlbd_pkg::CLS_JUMP
                                                        : vlbd_pkg::CLS_CALL;
            bytes_left_d  = 4'd1 << byte_i[4:3];
            byte_index_d  = 3'd0;
            value_shift_d = '0;
          end
        end else begin
          case (byte_i) inside
            vlbd_pkg::OPC_SYSCALL, vlbd_pkg::OPC_LIBCALL, vlbd_pkg::OPC_MODE:
              cur_class_d = byte_i[3:0] - 4'd1;
            vlbd_pkg::OPC_LONG: ;
            vlbd_pkg::OPC_ERROR, vlbd_pkg::OPC_NOP, vlbd_pkg::OPC_DUMP: begin
              res_valid_o = 1'b1;
              res_o = vlbd_pkg::res_clear((byte_i == vlbd_pkg::OPC_ERROR)
                                          ? vlbd_pkg::CLS_ERROR : byte_i[3:0] - 4'd1);
              res_o.last  = 1'b1;
            end
            default: begin
              res_valid_o = 1'b1;
              res_o       = vlbd_pkg::res_clear(vlbd_pkg::CLS_INVALID);
              res_o.last  = 1'b1;
            end
          endcase
        end
      end
      vlbd_pkg::PH_SHORTC: begin
        res_valid_o       = 1'b1;
        res_o             = vlbd_pkg::res_clear(cur_class_q);
        res_o.has_const   = 1'b1;
        res_o.const_value = 64'(byte_i);
        res_o.last        = 1'b1;
      end
      vlbd_pkg::PH_DISP: begin
        bytes_left_d  = left_dec;
        byte_index_d  = byte_index_q + 3'd1;
        value_shift_d = acc_val;
        if (left_dec == 4'd0) begin
          value_shift_d     = vlbd_pkg::sext_disp(acc_val, byte_index_q);
          res_valid_o       = 1'b1;
          res_o             = vlbd_pkg::res_clear(cur_class_q);
          res_o.has_const   = 1'b1;
          res_o.const_value = value_shift_d;
          res_o.last        = 1'b1;
        end
      end
      vlbd_pkg::PH_LID: index_byte_d = byte_i;
      vlbd_pkg::PH_LCOUNT: begin
        res_valid_o     = 1'b1;
        res_o           = vlbd_pkg::res_clear(vlbd_pkg::CLS_LONG);
        res_o.long_id   = index_byte_q;
        res_o.arg_count = byte_i;
        res_o.last      = byte_i == 8'd0;
        operands_left_d = byte_i;
        index_byte_d    = '0;
      end
      vlbd_pkg::PH_FLAGS: begin
        operand_flags_d = byte_i;
        index_byte_d    = '0;
        value_shift_d   = '0;
        byte_index_d    = 3'd0;
        bytes_left_d    = clen;
        if (!byte_i[vlbd_pkg::FB_RY] && clen == 4'd0) begin
          res_valid_o     = 1'b1;
          res_o           = vlbd_pkg::emit_operand(byte_i, 8'd0, 64'd0, ops_dec == 8'd0);
          operands_left_d = ops_dec;
        end
      end
      vlbd_pkg::PH_INDEX: begin
        index_byte_d = byte_i;
        if (bytes_left_q == 4'd0) begin
          res_valid_o     = 1'b1;
          res_o           = vlbd_pkg::emit_operand(operand_flags_q, byte_i, value_shift_q,
                                                   ops_dec == 8'd0);
          operands_left_d = ops_dec;
        end
      end
      vlbd_pkg::PH_OCONST: begin
        bytes_left_d  = left_dec;
        byte_index_d  = byte_index_q + 3'd1;
        value_shift_d = acc_val;
        if (left_dec == 4'd0) begin
          res_valid_o     = 1'b1;
          res_o           = vlbd_pkg::emit_operand(operand_flags_q, index_byte_q, acc_val,
                                                   ops_dec == 8'd0);
          operands_left_d = ops_dec;
        end
      end
      default: ;
    endcase
    // Only an accepted byte produces a word
    if (!fire_i) res_valid_o = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= vlbd_pkg::PH_OPCODE;
      bytes_left_q    <= '0;
      byte_index_q    <= '0;
      value_shift_q   <= '0;
      cur_class_q     <= '0;
      operands_left_q <= '0;
      operand_flags_q <= '0;
      index_byte_q    <= '0;
    end else if (fire_i) begin
      phase_q         <= phase_d;
      bytes_left_q    <= bytes_left_d;
      byte_index_q    <= byte_index_d;
      value_shift_q   <= value_shift_d;
      cur_class_q     <= cur_class_d;
      operands_left_q <= operands_left_d;
      operand_flags_q <= operand_flags_d;
      index_byte_q    <= index_byte_d;
    end
  end

  // Collecting phases always have bytes still to come
  a_disp_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == vlbd_pkg::PH_DISP || phase_q == vlbd_pkg::PH_OCONST)
      |-> bytes_left_q != 4'd0)
    else $error("collect phase with no bytes left");

  // An operand word needs an open operand count
  a_operand_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.op_class == vlbd_pkg::CLS_OPERAND) |-> operands_left_q != 8'd0)
    else $error("operand emitted with zero count");

  // Operand phases are only reached inside a long form with operands left
  a_flags_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == vlbd_pkg::PH_FLAGS || phase_q == vlbd_pkg::PH_INDEX)
      |-> operands_left_q != 8'd0)
    else $error("operand phase with zero count");

endmodule

// File: rtl/vlbd_outbuf.sv
// ----------------------------------------------------------------------------
// vlbd_outbuf
// Result register with a skid stage so the parser keeps taking bytes.
// ----------------------------------------------------------------------------
module vlbd_outbuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_valid_i,
  input  vlbd_pkg::res_t res_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output vlbd_pkg::res_t out_o
);

  logic           out_valid_q, out_valid_d;
  logic           skid_full_q, skid_full_d;
  vlbd_pkg::res_t out_q, out_d;
  vlbd_pkg::res_t skid_q, skid_d;
  logic           pop;

  assign pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    skid_full_d = skid_full_q;
    out_d       = out_q;
    skid_d      = skid_q;
    if (skid_full_q) begin
      // Drain the skid word first
      if (pop) begin
        out_d       = skid_q;
        skid_full_d = 1'b0;
      end
    end else if (res_valid_i) begin
      if (!out_valid_q || pop) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d      = res_i;
        skid_full_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      skid_full_q <= skid_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_full_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Skid word only exists behind a held output word
  a_skid_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q |-> out_valid_q)
    else $error("skid word without output word");

  // A word arriving while full would be lost
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q |-> !res_valid_i)
    else $error("result arrived while skid full");

  // Skid fills only when the output was held
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_full_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid filled without a stall");

endmodule

// File: rtl/variable_length_bytecode_decoder.sv
// ----------------------------------------------------------------------------
// variable_length_bytecode_decoder
// Decodes a byte stream of variable-length instructions into result words.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------
//  in      | sink      | in_valid_i / in_stall_o   | code_byte_i
//  out     | source    | out_valid_o / out_stall_i | op_class_o .. last_o
//
//  One byte is taken per cycle while in_stall_o is low; the parse state advances in the same cycle.
//  The word that a byte ends is registered in the output or skid stage.
//  Reset returns the parser to waiting for an opcode and empties the output.
//  in_stall_o rises only when a word waits in the skid stage behind a held
//  output word.
// ----------------------------------------------------------------------------
module variable_length_bytecode_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  code_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  op_class_o,
  output logic [7:0]  long_id_o,
  output logic [7:0]  arg_count_o,
  output logic        is_memory_o,
  output logic        has_rx_o,
  output logic [2:0]  rx_reg_o,
  output logic        has_ry_o,
  output logic [2:0]  ry_reg_o,
  output logic [1:0]  scale_log_o,
  output logic        has_const_o,
  output logic [63:0] const_value_o,
  output logic        last_o
);

  logic           fire;
  logic           full;
  logic           res_valid;
  vlbd_pkg::res_t res;
  vlbd_pkg::res_t out;

  assign in_stall_o = full;
  assign fire       = in_valid_i && !full;

  vlbd_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (code_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  vlbd_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out)
  );

  assign op_class_o    = out.op_class;
  assign long_id_o     = out.long_id;
  assign arg_count_o   = out.arg_count;
  assign is_memory_o   = out.is_memory;
  assign has_rx_o      = out.has_rx;
  assign rx_reg_o      = out.rx_reg;
  assign has_ry_o      = out.has_ry;
  assign ry_reg_o      = out.ry_reg;
  assign scale_log_o   = out.scale_log;
  assign has_const_o   = out.has_const;
  assign const_value_o = out.const_value;
  assign last_o        = out.last;

endmodule

// File: verif/variable_length_bytecode_decoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// variable_length_bytecode_decoder_test
// Drives instruction byte streams into the decoder under varying input gaps
// and output stalls, and checks every decoded word against a byte-level
// parse model held in a scoreboard.
// ----------------------------------------------------------------------------
module variable_length_bytecode_decoder_test;

  localparam int CLK_PERIOD  = 10;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_BYTES = 100;

  class decode_scoreboard;
    vlbd_pkg::phase_e parse_phase;
    logic [3:0]       bytes_left;
    logic [2:0]       byte_index;
    logic [63:0]      value_acc;
    logic [3:0]       cur_class;
    logic [7:0]       ops_left;
    logic [7:0]       op_flags;
    logic [7:0]       idx_byte;
    vlbd_pkg::res_t   pending_words[$];
    int               mismatches;

    function new();
      parse_phase = vlbd_pkg::PH_OPCODE;
      bytes_left  = '0;
      byte_index  = '0;
      value_acc   = '0;
      cur_class   = '0;
      ops_left    = '0;
      op_flags    = '0;
      idx_byte    = '0;
      mismatches  = 0;
    endfunction

    static function int unsigned const_bytes(input logic [7:0] flags);
      case (flags[4:3])
        vlbd_pkg::CSZ_ONE:   return 1;
        vlbd_pkg::CSZ_FOUR:  return 4;
        vlbd_pkg::CSZ_EIGHT: return 8;
        default:             return 0;
      endcase
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    function void gather(input logic [7:0] b);
      value_acc  = value_acc | ({56'd0, b} << (8 * byte_index));
      byte_index = byte_index + 3'd1;
      bytes_left = bytes_left - 4'd1;
    endfunction

    function vlbd_pkg::res_t close_operand();
      vlbd_pkg::res_t r;
      r             = '0;
      r.op_class    = vlbd_pkg::CLS_OPERAND;
      r.is_memory   = op_flags[vlbd_pkg::FB_MEM];
      r.has_rx      = op_flags[vlbd_pkg::FB_RX];
      if (op_flags[vlbd_pkg::FB_RX]) r.rx_reg = op_flags[7:5];
      if (op_flags[vlbd_pkg::FB_RY]) begin
        r.has_ry    = 1'b1;
        r.ry_reg    = idx_byte[2:0];
        r.scale_log = idx_byte[7:6];
      end
      if (op_flags[4:3] != vlbd_pkg::CSZ_NONE) begin
        r.has_const   = 1'b1;
        r.const_value = value_acc;
      end
      ops_left    = ops_left - 8'd1;
      r.last      = (ops_left == 8'd0);
      parse_phase = r.last ? vlbd_pkg::PH_OPCODE : vlbd_pkg::PH_FLAGS;
      return r;
    endfunction

    // Advance the parse by one accepted byte; queue the word it completes
    function void note_byte(input logic [7:0] b);
      vlbd_pkg::res_t r;
      logic           hit;
      int unsigned    n;
      r   = '0;
      hit = 1'b0;
      case (parse_phase)
        vlbd_pkg::PH_OPCODE: begin
          if (b[7:6] != vlbd_pkg::TOP_SHORT) begin
            if (b[5:3] != b[2:0]) begin
              r.op_class = vlbd_pkg::CLS_MOVSHORT;
              r.rx_reg   = b[5:3];
              r.ry_reg   = b[2:0];
              r.last     = 1'b1;
              hit        = 1'b1;
            end else if (b[5]) begin
              r.op_class = vlbd_pkg::CLS_INVALID;
              r.last     = 1'b1;
              hit        = 1'b1;
            end else begin
              cur_class   = (b[7:6] == vlbd_pkg::TOP_JUMP) ? vlbd_pkg::CLS_JUMP
                                                           : vlbd_pkg::CLS_CALL;
              bytes_left  = 4'd1 << b[4:3];
              byte_index  = '0;
              value_acc   = '0;
              parse_phase = vlbd_pkg::PH_DISP;
            end
          end else begin
            case (b)
              vlbd_pkg::OPC_ERROR, vlbd_pkg::OPC_NOP, vlbd_pkg::OPC_DUMP: begin
                r.op_class = (b == vlbd_pkg::OPC_ERROR) ? vlbd_pkg::CLS_ERROR :
                             (b == vlbd_pkg::OPC_NOP) ? vlbd_pkg::CLS_NOP
                                                      : vlbd_pkg::CLS_DUMP;
                r.last     = 1'b1;
                hit        = 1'b1;
              end
              vlbd_pkg::OPC_SYSCALL, vlbd_pkg::OPC_LIBCALL, vlbd_pkg::OPC_MODE: begin
                cur_class   = (b == vlbd_pkg::OPC_SYSCALL) ? vlbd_pkg::CLS_SYSCALL :
                              (b == vlbd_pkg::OPC_LIBCALL) ? vlbd_pkg::CLS_LIBCALL
                                                           : vlbd_pkg::CLS_MODE;
                parse_phase = vlbd_pkg::PH_SHORTC;
              end
              vlbd_pkg::OPC_LONG: parse_phase = vlbd_pkg::PH_LID;
              default: begin
                r.op_class = vlbd_pkg::CLS_INVALID;
                r.last     = 1'b1;
                hit        = 1'b1;
              end
            endcase
          end
        end
        vlbd_pkg::PH_SHORTC: begin
          r.op_class    = cur_class;
          r.has_const   = 1'b1;
          r.const_value = {56'd0, b};
          r.last        = 1'b1;
          hit           = 1'b1;
          parse_phase   = vlbd_pkg::PH_OPCODE;
        end
        vlbd_pkg::PH_DISP: begin
          n = byte_index + 1;
          gather(b);
          if (bytes_left == 4'd0) begin
            // sign-extend from the top byte collected
            if (n < 8 && value_acc[8 * n - 1]) value_acc = value_acc | (~64'd0 << (8 * n));
            r.op_class    = cur_class;
            r.has_const   = 1'b1;
            r.const_value = value_acc;
            r.last        = 1'b1;
            hit           = 1'b1;
            parse_phase   = vlbd_pkg::PH_OPCODE;
          end
        end
        vlbd_pkg::PH_LID: begin
          idx_byte    = b;
          parse_phase = vlbd_pkg::PH_LCOUNT;
        end
        vlbd_pkg::PH_LCOUNT: begin
          r.op_class  = vlbd_pkg::CLS_LONG;
          r.long_id   = idx_byte;
          r.arg_count = b;
          r.last      = (b == 8'd0);
          hit         = 1'b1;
          ops_left    = b;
          idx_byte    = '0;
          parse_phase = (b == 8'd0) ? vlbd_pkg::PH_OPCODE : vlbd_pkg::PH_FLAGS;
        end
        vlbd_pkg::PH_FLAGS: begin
          op_flags   = b;
          idx_byte   = '0;
          value_acc  = '0;
          byte_index = '0;
          bytes_left = 4'(const_bytes(b));
          if (b[vlbd_pkg::FB_RY]) parse_phase = vlbd_pkg::PH_INDEX;
          else if (bytes_left != 4'd0) parse_phase = vlbd_pkg::PH_OCONST;
          else begin
            r   = close_operand();
            hit = 1'b1;
          end
        end
        vlbd_pkg::PH_INDEX: begin
          idx_byte = b;
          if (bytes_left != 4'd0) parse_phase = vlbd_pkg::PH_OCONST;
          else begin
            r   = close_operand();
            hit = 1'b1;
          end
        end
        default: begin
          gather(b);
          if (bytes_left == 4'd0) begin
            r   = close_operand();
            hit = 1'b1;
          end
        end
      endcase
      if (hit) pending_words.push_back(r);
    endfunction

    function void cmp_field(input string name, input logic [63:0] want,
                            input logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_word(input vlbd_pkg::res_t got);
      vlbd_pkg::res_t want;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: word with no expectation, op_class %0d", $time, got.op_class);
        return;
      end
      want = pending_words.pop_front();
      cmp_field("op_class", 64'(want.op_class), 64'(got.op_class));
      cmp_field("long_id", 64'(want.long_id), 64'(got.long_id));
      cmp_field("arg_count", 64'(want.arg_count), 64'(got.arg_count));
      cmp_field("is_memory", 64'(want.is_memory), 64'(got.is_memory));
      cmp_field("has_rx", 64'(want.has_rx), 64'(got.has_rx));
      cmp_field("rx_reg", 64'(want.rx_reg), 64'(got.rx_reg));
      cmp_field("has_ry", 64'(want.has_ry), 64'(got.has_ry));
      cmp_field("ry_reg", 64'(want.ry_reg), 64'(got.ry_reg));
      cmp_field("scale_log", 64'(want.scale_log), 64'(got.scale_log));
      cmp_field("has_const", 64'(want.has_const), 64'(got.has_const));
      cmp_field("const_value", want.const_value, got.const_value);
      cmp_field("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  code_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  op_class_o;
  logic [7:0]  long_id_o;
  logic [7:0]  arg_count_o;
  logic        is_memory_o;
  logic        has_rx_o;
  logic [2:0]  rx_reg_o;
  logic        has_ry_o;
  logic [2:0]  ry_reg_o;
  logic [1:0]  scale_log_o;
  logic        has_const_o;
  logic [63:0] const_value_o;
  logic        last_o;

  decode_scoreboard sb;
  int unsigned      send_gap_pct;
  int unsigned      recv_stall_pct;
  int unsigned      bytes_sent;
  int               hold_seq;
  int               cycles;

  variable_length_bytecode_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .code_byte_i   (code_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .op_class_o    (op_class_o),
    .long_id_o     (long_id_o),
    .arg_count_o   (arg_count_o),
    .is_memory_o   (is_memory_o),
    .has_rx_o      (has_rx_o),
    .rx_reg_o      (rx_reg_o),
    .has_ry_o      (has_ry_o),
    .ry_reg_o      (ry_reg_o),
    .scale_log_o   (scale_log_o),
    .has_const_o   (has_const_o),
    .const_value_o (const_value_o),
    .last_o        (last_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("variable_length_bytecode_decoder verification failed");
      $finish;
    end
  end

  // Output side: check each accepted word, then pick the next stall
  always @(posedge clk_i) begin : receiver
    int seen_seq;
    int hold_left;
    vlbd_pkg::res_t got;
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        got.op_class    = op_class_o;
        got.long_id     = long_id_o;
        got.arg_count   = arg_count_o;
        got.is_memory   = is_memory_o;
        got.has_rx      = has_rx_o;
        got.rx_reg      = rx_reg_o;
        got.has_ry      = has_ry_o;
        got.ry_reg      = ry_reg_o;
        got.scale_log   = scale_log_o;
        got.has_const   = has_const_o;
        got.const_value = const_value_o;
        got.last        = last_o;
        sb.check_word(got);
      end
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Offer one byte after a random gap and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    code_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic gen_long(input logic [7:0] count, input logic lean);
    logic [7:0] flags;
    send_byte(vlbd_pkg::OPC_LONG);
    send_byte(rand_byte());
    send_byte(count);
    for (int i = 0; i < count; i++) begin
      flags = rand_byte();
      // one-byte operands in lean mode to keep long forms short
      if (lean) begin
        flags[4:3]              = vlbd_pkg::CSZ_NONE;
        flags[vlbd_pkg::FB_RY]  = 1'b0;
      end
      send_byte(flags);
      if (flags[vlbd_pkg::FB_RY]) send_byte(rand_byte());
      repeat (decode_scoreboard::const_bytes(flags)) send_byte(rand_byte());
    end
  endtask

  task automatic gen_instr();
    int unsigned roll;
    int unsigned sz;
    logic [2:0]  rx;
    logic [2:0]  ry;
    logic [1:0]  top;
    roll = $urandom_range(99);
    top  = 2'($urandom_range(3, 1));
    if (roll < 10) begin
      case ($urandom_range(2))
        0:       send_byte(vlbd_pkg::OPC_ERROR);
        1:       send_byte(vlbd_pkg::OPC_NOP);
        default: send_byte(vlbd_pkg::OPC_DUMP);
      endcase
    end else if (roll < 22) begin
      case ($urandom_range(2))
        0:       send_byte(vlbd_pkg::OPC_SYSCALL);
        1:       send_byte(vlbd_pkg::OPC_LIBCALL);
        default: send_byte(vlbd_pkg::OPC_MODE);
      endcase
      send_byte(rand_byte());
    end else if (roll < 36) begin
      rx = 3'($urandom_range(7));
      ry = rx + 3'($urandom_range(7, 1));
      send_byte({top, rx, ry});
    end else if (roll < 54) begin
      sz = $urandom_range(3);
      send_byte({top, 3'(sz), 3'(sz)});
      repeat (1 << sz) send_byte(rand_byte());
    end else if (roll < 86) begin
      if ($urandom_range(9) == 0) gen_long(8'($urandom_range(24)), 1'b0);
      else gen_long(8'($urandom_range(4)), 1'b0);
    end else if (roll < 94) begin
      if ($urandom_range(1) == 0) begin
        send_byte(8'($urandom_range(63, 7)));
      end else begin
        sz = $urandom_range(7, 4);
        send_byte({top, 3'(sz), 3'(sz)});
      end
    end else begin
      // stray byte: whatever state it leaves, the parse goes on from there
      send_byte(rand_byte());
    end
  endtask

  initial begin
    logic [7:0] directed[$];
    int unsigned target;
    sb             = new();
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    code_byte_i    = 8'h00;
    out_stall_i    = 1'b0;
    send_gap_pct   = 33;
    recv_stall_pct = 59;
    bytes_sent     = 0;
    hold_seq       = 0;
    cycles         = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // standalone ops, short constants, moves, jump/call extremes,
    // undefined opcodes and sizes, empty and populated long forms
    directed = '{vlbd_pkg::OPC_ERROR, vlbd_pkg::OPC_NOP, vlbd_pkg::OPC_DUMP,
                 vlbd_pkg::OPC_SYSCALL, 8'h00, vlbd_pkg::OPC_LIBCALL, 8'hFF,
                 vlbd_pkg::OPC_MODE, 8'h80,
                 8'h47, 8'hFE, 8'hC0, 8'h80, 8'h49, 8'hFF, 8'h7F,
                 8'h07, 8'h3F, 8'hFF,
                 vlbd_pkg::OPC_LONG, 8'hFF, 8'h00,
                 vlbd_pkg::OPC_LONG, 8'h00, 8'h02, 8'h01, 8'hE6, 8'hFF};
    foreach (directed[i]) send_byte(directed[i]);
    wait_drained();

    for (int p = 0; p < 3; p++) begin
      send_gap_pct   = (p == 0) ? 33 : (p == 1) ? 59 : 0;
      recv_stall_pct = (p == 0) ? 59 : (p == 1) ? 33 : 0;
      if (p == 2) begin
        // hold the output off while bytes keep coming, then a full-count long form
        hold_seq <= hold_seq + 1;
        gen_long(8'hFF, 1'b1);
      end
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) gen_instr();
      wait_drained();
    end

    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("variable_length_bytecode_decoder verification clean");
    end else begin
      $display("variable_length_bytecode_decoder verification failed");
    end
    $finish;
  end

endmodule
